/* design/d2i_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2i_pkg
// Shared types and constants for the binary64 to integer converter.
// ----------------------------------------------------------------------------
package d2i_pkg;

    localparam int ValueWidth  = 64;
    localparam int TypeWidth   = 3;
    localparam int ExpWidth    = 11;
    localparam int FracWidth   = 52;
    localparam int Bias        = 1023;

    // decoded fields after stage 1
    typedef struct packed {
        logic                  neg;
        logic                  is_nan;
        logic                  big;
        logic [ExpWidth-1:0]   expf;
        logic [FracWidth:0]    sig;
        logic                  is_signed;
        logic [1:0]            wsel;
    } dec_t;

    // magnitude after stage 2
    typedef struct packed {
        logic                  neg;
        logic                  is_nan;
        logic                  big;
        logic [63:0]           mag;
        logic                  is_signed;
        logic [1:0]            wsel;
    } mag_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        clipped;
        logic        was_nan;
    } res_t;

endpackage

/* design/double_to_int_saturating_convert_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_int_saturating_convert_unit
// Accepts one item per cycle while the output is not stalled.
// Stages: decode, align and round, clamp; a stall holds the occupied stages, empty ones still fill.
// Reset (async, active low) clears valid bits and sets target_type to int8.
// ----------------------------------------------------------------------------
module double_to_int_saturating_convert_unit
    import d2i_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TypeWidth-1:0] cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // value_bits
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // result_bits
    output logic [7:0]           m_axis_tuser    // clipped, was_nan, zero fill
);

    logic [TypeWidth-1:0] type_reg;
    logic v1_reg, v2_reg, v3_reg;
    dec_t dec_reg, dec_next;
    mag_t mag_reg, mag_next;
    res_t res_reg, res_next;
    logic adv3, adv2, adv1;

    assign adv3 = m_axis_tready || !v3_reg;
    assign adv2 = adv3 || !v2_reg;
    assign adv1 = adv2 || !v1_reg;
    assign s_axis_tready = adv1;

    d2i_decode u_dec (.value_bits(s_axis_tdata), .target_type(type_reg), .dec(dec_next));
    d2i_round  u_rnd (.dec(dec_reg), .mg(mag_next));
    d2i_clamp  u_clp (.mg(mag_reg), .res(res_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                type_reg <= cfg_wdata;
            if (adv1)
                v1_reg <= s_axis_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            dec_reg <= dec_next;
        if (adv2)
            mag_reg <= mag_next;
        if (adv3)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = res_reg.result_bits;
    assign m_axis_tuser  = {6'd0, res_reg.was_nan, res_reg.clipped};

`ifndef SYNTHESIS
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0 && !m_axis_tuser[0])
        else $error("nan result not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !m_axis_tready |=> v3_reg)
        else $error("output item lost");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_axis_tready)
        else $error("empty stage stalls input");
`endif

endmodule

/* design/d2i_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2i_decode
// Splits a binary64 pattern into sign, exponent and significand.
// ----------------------------------------------------------------------------
module d2i_decode
    import d2i_pkg::*;
(
    input  logic [ValueWidth-1:0] value_bits,
    input  logic [TypeWidth-1:0]  target_type,
    output dec_t                  dec
);

    logic [ExpWidth-1:0]  expf;
    logic [FracWidth-1:0] frac;

    assign expf = value_bits[62:52];
    assign frac = value_bits[51:0];

    always_comb
    begin
        dec.neg       = value_bits[63];
        dec.expf      = expf;
        dec.sig       = {1'b1, frac};
        dec.is_nan    = (expf == '1) && (frac != '0);
        // inf, NaN or exponent above 63
        dec.big       = (expf == '1) || (expf > ExpWidth'(Bias + 63));
        dec.is_signed = ~target_type[2];
        dec.wsel      = target_type[1:0];
    end

endmodule

/* design/d2i_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2i_round
// Aligns the significand and rounds half away from zero.
// ----------------------------------------------------------------------------
module d2i_round
    import d2i_pkg::*;
(
    input  dec_t dec,
    output mag_t mg
);

    logic [116:0] wide;
    logic [6:0]   sh;
    logic [64:0]  aligned;   // integer part plus one fraction bit

    always_comb
    begin
        mg.neg       = dec.neg;
        mg.is_nan    = dec.is_nan;
        mg.big       = dec.big;
        mg.is_signed = dec.is_signed;
        mg.wsel      = dec.wsel;
        // shift amount: e+1 where e = expf - 1023, valid for e in -1..63
        sh      = 7'(dec.expf - ExpWidth'(Bias - 1));
        wide    = {64'd0, dec.sig} << sh;
        aligned = wide[117-1:52];
        if (dec.expf == '0 || dec.expf < ExpWidth'(Bias - 1) || dec.big)
            mg.mag = '0;
        else
            mg.mag = aligned[64:1] + 64'(aligned[0]);
    end

endmodule

/* design/d2i_clamp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2i_clamp
// Range check against the target type and final sign handling.
// ----------------------------------------------------------------------------
module d2i_clamp
    import d2i_pkg::*;
(
    input  mag_t mg,
    output res_t res
);

    logic [63:0] maxv;
    logic [63:0] negmax;
    logic [7:0]  w;

    always_comb
    begin
        w = 8'd8 << mg.wsel;
        if (mg.is_signed)
        begin
            negmax = 64'd1 << (w - 8'd1);
            maxv   = negmax - 64'd1;
        end
        else
        begin
            negmax = '0;
            maxv   = (mg.wsel == 2'd3) ? '1 : ((64'd1 << w) - 64'd1);
        end
        res.was_nan     = mg.is_nan;
        res.clipped     = 1'b0;
        res.result_bits = '0;
        if (!mg.is_nan)
        begin
            if (!mg.neg)
            begin
                if (mg.big || mg.mag > maxv)
                begin
                    res.result_bits = maxv;
                    res.clipped     = 1'b1;
                end
                else
                    res.result_bits = mg.mag;
            end
            else
            begin
                if (mg.big || mg.mag > negmax)
                begin
                    res.result_bits = 64'd0 - negmax;
                    res.clipped     = 1'b1;
                end
                else
                    res.result_bits = 64'd0 - mg.mag;
            end
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the binary64 to integer converter against an in-bench predictor
// over all eight target types, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    import d2i_pkg::*;

    typedef enum logic [2:0] {
        T_I8 = 3'd0, T_I16 = 3'd1, T_I32 = 3'd2, T_I64 = 3'd3,
        T_U8 = 3'd4, T_U16 = 3'd5, T_U32 = 3'd6, T_U64 = 3'd7
    } int_kind_e;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 10;

    class conv_scoreboard;
        res_t pending_q[$];
        int   errors;

        function res_t predict(logic [63:0] v, logic [2:0] kind);
            res_t        r;
            logic        neg;
            logic [10:0] expf;
            logic [52:0] sig;
            logic [63:0] mag;
            logic [63:0] maxv;
            logic [63:0] negmax;
            logic        big;
            int          e;
            int          w;
            neg  = v[63];
            expf = v[62:52];
            sig  = {1'b1, v[51:0]};
            mag  = '0;
            big  = 1'b0;
            r    = '0;
            w    = 8 << kind[1:0];
            if (expf == 11'h7ff) begin
                if (v[51:0] != 0) begin
                    r.was_nan = 1'b1;
                    return r;
                end
                big = 1'b1;
            end
            else begin
                e = int'(expf) - 1023;
                if (expf == 0 || e < -1)
                    mag = '0;
                else if (e <= 51)
                    // round half away: add the first dropped bit
                    mag = (64'(sig) >> (52 - e)) + ((64'(sig) >> (51 - e)) & 64'd1);
                else if (e <= 63)
                    mag = 64'(sig) << (e - 52);
                else
                    big = 1'b1;
            end
            if (!kind[2]) begin
                maxv   = (64'd1 << (w - 1)) - 64'd1;
                negmax = 64'd1 << (w - 1);
            end
            else begin
                maxv   = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
                negmax = '0;
            end
            if (!neg) begin
                if (big || mag > maxv) begin
                    r.result_bits = maxv;
                    r.clipped     = 1'b1;
                end
                else
                    r.result_bits = mag;
            end
            else begin
                if (big || mag > negmax) begin
                    r.result_bits = -negmax;
                    r.clipped     = 1'b1;
                end
                else
                    r.result_bits = -mag;
            end
            return r;
        endfunction

        function void note_input(logic [63:0] v, logic [2:0] kind);
            pending_q.push_back(predict(v, kind));
        endfunction

        function void check_result(logic [63:0] data, logic [7:0] user);
            res_t exp_r;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (data !== exp_r.result_bits) begin
                $error("result_bits exp %h got %h", exp_r.result_bits, data);
                errors++;
            end
            if (user[0] !== exp_r.clipped) begin
                $error("clipped exp %b got %b", exp_r.clipped, user[0]);
                errors++;
            end
            if (user[1] !== exp_r.was_nan) begin
                $error("was_nan exp %b got %b", exp_r.was_nan, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;   // clipped, was_nan, zero fill

    conv_scoreboard sb = new();
    logic [2:0] cur_kind = T_I8;
    bit         quiet_tail = 0;
    int         idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    double_to_int_saturating_convert_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // receiver side: check and random backpressure
    always @(posedge clk)
    begin
        int n;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (rst_n && (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 10);
            m_axis_tready <= 1'b0;
            repeat (n) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic write_kind(logic [2:0] kind);
        cfg_we    <= 1'b1;
        cfg_wdata <= kind;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_kind  = kind;
    endtask

    task automatic wait_empty();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_value(logic [63:0] v);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(v, cur_kind);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        logic [10:0] ex;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: ex = 11'h7ff;
            1: ex = 11'h000;
            2: ex = 11'(1022 + $urandom_range(0, 1));
            3: ex = 11'(1023 + 62 + $urandom_range(0, 2));
            4: ex = 11'($urandom());
            default: ex = 11'(1023 + $urandom_range(0, 64));
        endcase
        if ($urandom_range(0, 3) == 0)
            v[51:0] = (ex >= 1023 && ex <= 1074) ? 52'(1) << (1074 - ex) : v[51:0];
        v[62:52] = ex;
        return v;
    endfunction

    logic [63:0] directed_q[$] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000, 64'h3FDF_FFFF_FFFF_FFFF,
        64'h3FF8_0000_0000_0000, 64'hC004_0000_0000_0000, 64'h405F_C000_0000_0000,
        64'h4060_0000_0000_0000, 64'hC060_0000_0000_0000, 64'h406F_E000_0000_0000,
        64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000, 64'h43F0_0000_0000_0000,
        64'h43EF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
        64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0001,
        64'h7FEF_FFFF_FFFF_FFFF, 64'hBFF0_0000_0000_0000, 64'h41E0_0000_0000_0000
    };

    initial
    begin
        int kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset type is int8
        for (int i = 0; i < 6; i++)
            send_value(directed_q[i]);
        wait_empty();
        for (kind = 0; kind < 8; kind++) begin
            write_kind(3'(kind));
            foreach (directed_q[i])
                send_value(directed_q[i]);
            wait_empty();
        end
        for (int ph = 0; ph < 8; ph++) begin
            write_kind((ph == 0) ? T_U64 : (ph == 1) ? T_I64 : 3'($urandom_range(0, 7)));
            if (ph == 7)
                quiet_tail = 1;
            for (int i = 0; i < 60; i++)
                send_value(rand_value());
            wait_empty();
        end
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
